/* sv/pre_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pre_pkg
// Shared types, constants and helpers of the printable run extractor.
// ---------------------------------------------------------------------------
package pre_pkg;

    localparam int MaxMinLength     = 32;
    localparam int CntW             = $clog2(MaxMinLength + 1);
    localparam int AddrW            = $clog2(MaxMinLength);
    localparam int CfgW             = 6;
    localparam int ByteW            = 8;
    localparam int QueueDepth       = 2;

    localparam logic [CfgW-1:0]  DefaultMinLength = CfgW'(5);
    localparam logic [ByteW-1:0] NewlineByte      = 8'd10;
    localparam logic [ByteW-1:0] PrintLow         = 8'd32;
    localparam logic [ByteW-1:0] PrintHigh        = 8'd126;
    localparam logic [ByteW-1:0] TabByte          = 8'd9;

    typedef logic [CntW-1:0]  t_cnt;
    typedef logic [AddrW-1:0] t_addr;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             is_line_end;
        logic             last;
    } t_out_item;

    // work for the back end produced by one input request
    typedef struct packed {
        logic             has_flush;
        t_cnt             flush_len;
        logic             has_byte;
        logic [ByteW-1:0] data_byte;
        logic             has_newline;
    } t_cmd;

    typedef struct packed {
        logic flush_done;
    } t_back_stat;

    function automatic logic is_text_byte(input logic [ByteW-1:0] b);
        return (b inside {[PrintLow:PrintHigh]}) || (b == TabByte);
    endfunction

endpackage
`default_nettype wire

/* sv/pre_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pre_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module pre_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/pre_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pre_front
// Classifies input bytes, tracks the run state, fills the run buffer and
// queues the output work for each accepted request.
// ---------------------------------------------------------------------------
module pre_front import pre_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CfgW-1:0]  i_cfg_data,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output t_cmd                  o_q_cmd,
    input  wire t_back_stat       i_back_stat,
    output logic                  o_buf_we,
    output t_addr                 o_buf_addr,
    output logic [ByteW-1:0]      o_buf_wdata
);

    localparam int CmpW = (CntW > CfgW) ? CntW : CfgW;

    logic [CfgW-1:0] r_min_length;
    t_cnt            r_run_count, n_run_count;
    logic            r_passing, n_passing;
    logic            r_flush_busy;

    logic            w_printable;
    logic            w_needs_write;
    logic            w_accept;
    logic            w_has_room;
    logic [CmpW-1:0] w_min_ext;
    logic [CmpW-1:0] w_eff_ext;
    t_cnt            w_eff_min;
    t_cnt            w_cnt_after;
    t_cmd            w_cmd;

    assign w_printable   = is_text_byte(i_in_data.data_byte);
    assign w_needs_write = w_printable && !r_passing;
    // a new run must not overwrite the buffer while a flush still reads it
    assign o_in_ready    = !i_q_full && !(w_needs_write && r_flush_busy);
    assign w_accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready   = 1'b1;

    assign w_min_ext = CmpW'(r_min_length);
    always_comb begin
        if (w_min_ext == '0) begin
            w_eff_ext = CmpW'(1);
        end else if (w_min_ext > CmpW'(MaxMinLength)) begin
            w_eff_ext = CmpW'(MaxMinLength);
        end else begin
            w_eff_ext = w_min_ext;
        end
    end
    assign w_eff_min = CntW'(w_eff_ext);

    assign w_has_room  = r_run_count < CntW'(MaxMinLength);
    assign w_cnt_after = w_has_room ? (r_run_count + CntW'(1)) : r_run_count;

    always_comb begin
        w_cmd       = '0;
        n_run_count = r_run_count;
        n_passing   = r_passing;
        if (w_printable) begin
            if (r_passing) begin
                w_cmd.has_byte  = 1'b1;
                w_cmd.data_byte = i_in_data.data_byte;
            end else if (w_cnt_after >= w_eff_min) begin
                w_cmd.has_flush = 1'b1;
                w_cmd.flush_len = w_cnt_after;
                n_run_count     = '0;
                n_passing       = 1'b1;
            end else begin
                n_run_count = w_cnt_after;
            end
            if (i_in_data.end_of_input) begin
                w_cmd.has_newline = n_passing;
                n_passing         = 1'b0;
                n_run_count       = '0;
            end
        end else begin
            w_cmd.has_newline = r_passing;
            n_passing         = 1'b0;
            n_run_count       = '0;
        end
    end

    assign o_q_cmd     = w_cmd;
    assign o_q_push    = w_accept && (w_cmd.has_flush || w_cmd.has_byte || w_cmd.has_newline);
    assign o_buf_we    = w_accept && w_needs_write && w_has_room;
    assign o_buf_addr  = r_run_count[AddrW-1:0];
    assign o_buf_wdata = i_in_data.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= DefaultMinLength;
            r_run_count  <= '0;
            r_passing    <= 1'b0;
            r_flush_busy <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_min_length <= i_cfg_data;
            end
            if (w_accept) begin
                r_run_count <= n_run_count;
                r_passing   <= n_passing;
            end
            if (w_accept && w_cmd.has_flush) begin
                r_flush_busy <= 1'b1;
            end else if (i_back_stat.flush_done) begin
                r_flush_busy <= 1'b0;
            end
        end
    end

    a_no_write_during_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_buf_we |-> !r_flush_busy)
        else $error("run buffer written while a flush is outstanding");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> !i_q_full)
        else $error("command pushed into a full queue");

    a_flush_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && o_q_cmd.has_flush) |=> r_flush_busy)
        else $error("flush queued without marking the buffer busy");

endmodule
`default_nettype wire

/* sv/pre_cmd_fifo.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pre_cmd_fifo
// Short command queue between the front and back ends.
// ---------------------------------------------------------------------------
module pre_cmd_fifo import pre_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntQW = $clog2(QueueDepth + 1);

    t_cmd             r_mem [QueueDepth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntQW-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = r_count == CntQW'(QueueDepth);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CntQW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CntQW'(1);
            end
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntQW'(QueueDepth))
        else $error("queue count beyond depth");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

    a_ptrs_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with an empty count");

endmodule
`default_nettype wire

/* sv/pre_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pre_back
// Executes queued commands: flushes the run buffer, passes bytes through and
// closes emitted runs with a newline, into a registered output stage.
// ---------------------------------------------------------------------------
module pre_back import pre_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_cmd             i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_rd_en,
    output t_addr                 o_rd_addr,
    input  wire logic [ByteW-1:0] i_rd_data,
    output t_back_stat            o_back_stat,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FLUSH = 3'b010,
        S_NL    = 3'b100
    } t_back_state;

    t_back_state r_state, n_state;
    t_cnt        r_idx, n_idx;
    t_cnt        r_len, n_len;
    logic        r_nl, n_nl;
    logic        r_rd_pend, n_rd_pend;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        w_can_load;
    logic        w_load;
    t_out_item   w_load_item;
    logic        w_flush_done;

    assign w_can_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_len        = r_len;
        n_nl         = r_nl;
        n_rd_pend    = r_rd_pend;
        o_q_pop      = 1'b0;
        o_rd_en      = 1'b0;
        w_load       = 1'b0;
        w_load_item  = '0;
        w_flush_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.has_flush) begin
                        o_q_pop = 1'b1;
                        n_len   = i_q_cmd.flush_len;
                        n_idx   = '0;
                        n_nl    = i_q_cmd.has_newline;
                        n_state = S_FLUSH;
                    end else if (w_can_load) begin
                        o_q_pop = 1'b1;
                        w_load  = 1'b1;
                        if (i_q_cmd.has_byte) begin
                            w_load_item.out_byte = i_q_cmd.data_byte;
                            w_load_item.last     = !i_q_cmd.has_newline;
                            if (i_q_cmd.has_newline) begin
                                n_state = S_NL;
                            end
                        end else begin
                            w_load_item.out_byte    = NewlineByte;
                            w_load_item.is_line_end = 1'b1;
                            w_load_item.last        = 1'b1;
                        end
                    end
                end
            end
            S_FLUSH: begin
                // read data is held in the RAM until the output stage takes it
                o_rd_en   = (r_idx < r_len) && (!r_rd_pend || w_can_load);
                n_rd_pend = o_rd_en || (r_rd_pend && !w_can_load);
                if (o_rd_en) begin
                    n_idx = r_idx + CntW'(1);
                end
                if (r_rd_pend && w_can_load) begin
                    w_load               = 1'b1;
                    w_load_item.out_byte = i_rd_data;
                    w_load_item.last     = (r_idx == r_len) && !r_nl;
                    if (r_idx == r_len) begin
                        w_flush_done = 1'b1;
                        n_state      = r_nl ? S_NL : S_IDLE;
                    end
                end
            end
            S_NL: begin
                if (w_can_load) begin
                    w_load                  = 1'b1;
                    w_load_item.out_byte    = NewlineByte;
                    w_load_item.is_line_end = 1'b1;
                    w_load_item.last        = 1'b1;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr              = r_idx[AddrW-1:0];
    assign o_back_stat.flush_done = w_flush_done;
    assign o_out_valid            = r_out_valid;
    assign o_out_data             = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_len <= n_len;
        r_nl  <= n_nl;
        if (w_load) begin
            r_out <= w_load_item;
        end
    end

    a_read_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (r_idx < r_len))
        else $error("buffer read past the flushed run");

    a_held_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && r_rd_pend && !w_can_load) |=> $stable(i_rd_data))
        else $error("pending read data changed before it was taken");

    a_pending_only_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == S_FLUSH))
        else $error("read pending outside a flush");

endmodule
`default_nettype wire

/* sv/printable_run_extractor.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// printable_run_extractor
// Finds runs of printable bytes and emits those reaching the minimum length.
// ---------------------------------------------------------------------------
// Path: a pass-through byte or newline goes through the command queue and
//   the output register; a flush adds the buffer RAM read port and then sends
//   1 byte/cycle while the output is ready.
// Throughput: 1 input request per cycle while the 2-entry command queue has
//   room; a flush holds the back end through its dequeue and the buffer RAM
//   reads, and new run bytes stall until that flush has read the buffer.
// Reset: synchronous, active low; clears run state and queue, min_length=5.
// ---------------------------------------------------------------------------
module printable_run_extractor import pre_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire t_in_item        i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output t_out_item            o_out_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [CfgW-1:0] i_cfg_data
);

    logic             w_q_full;
    logic             w_q_push;
    t_cmd             w_q_cmd_in;
    logic             w_q_pop;
    logic             w_q_valid;
    t_cmd             w_q_cmd_out;
    t_back_stat       w_back_stat;
    logic             w_buf_we;
    t_addr            w_buf_waddr;
    logic [ByteW-1:0] w_buf_wdata;
    logic             w_rd_en;
    t_addr            w_rd_addr;
    logic [ByteW-1:0] w_rd_data;

    pre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_cmd     (w_q_cmd_in),
        .i_back_stat (w_back_stat),
        .o_buf_we    (w_buf_we),
        .o_buf_addr  (w_buf_waddr),
        .o_buf_wdata (w_buf_wdata)
    );

    pre_ram #(
        .Width (ByteW),
        .Depth (MaxMinLength)
    ) u_run_buf (
        .i_clk   (i_clk),
        .i_we    (w_buf_we),
        .i_waddr (w_buf_waddr),
        .i_wdata (w_buf_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    pre_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_q_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd_out)
    );

    pre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd_out),
        .o_q_pop     (w_q_pop),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_back_stat (w_back_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
